@@ hdl/battery_gauge_sequencer_assert.svh @@
// ---------------------------------------------------------------------------
// battery gauge sequencer assertion macros
// concurrent checks that drop out of synthesis builds
// ---------------------------------------------------------------------------
`ifndef BATTERY_GAUGE_SEQUENCER_ASSERT_SVH
`define BATTERY_GAUGE_SEQUENCER_ASSERT_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define BGS_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define BGS_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`else

`define BGS_ASSERT_IMP(label, clk, rst_n, ante, cons, msg)
`define BGS_ASSERT_NXT(label, clk, rst_n, ante, cons, msg)

`endif

`endif

@@ hdl/bgs_pkg.sv @@
// ---------------------------------------------------------------------------
// bgs_pkg
// shared types, widths and constants of the battery gauge sequencer
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package bgs_pkg;

	localparam int MAX_SAMPLES = 64;

	localparam int NOW_W = 32;
	localparam int RAW_W = 16;
	localparam int MV_W  = 20;
	localparam int LVL_W = 7;
	localparam int CNT_W = $clog2(MAX_SAMPLES + 1);
	localparam int SUM_W = MV_W + $clog2(MAX_SAMPLES);

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 20;

	localparam logic [CFG_IDX_W-1:0] CFG_STABILIZE_MS = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_MEASURE_MS   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_POLL_SECONDS = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_ADC_BITS     = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_VREF_MV      = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_DIVIDER_Q8   = 3'd5;
	localparam logic [CFG_IDX_W-1:0] CFG_MIN_BATT_MV  = 3'd6;
	localparam logic [CFG_IDX_W-1:0] CFG_MAX_BATT_MV  = 3'd7;

	localparam logic [MV_W-1:0]  MV_MAX     = '1;
	localparam logic [LVL_W-1:0] LVL_FULL   = 7'd100;
	localparam logic [11:0]      DIV_UNITY  = 12'd256;
	localparam int               POLL_SCALE = 1000;

	// serial multiplier
	localparam int MUL_A_W   = 32;
	localparam int MUL_B_W   = 16;
	localparam int MUL_P_W   = 48;
	localparam int MUL_CNT_W = $clog2(MUL_B_W + 1);

	// serial divider
	localparam int DIV_NUM_W = 36;
	localparam int DIV_DEN_W = 31;
	localparam int DIV_CNT_W = $clog2(DIV_NUM_W + 1);

	// q4.8 divider ratio carries this shift, removed from the product before the full-scale division
	localparam int MV_SHIFT = 8;

	typedef struct packed {
		logic [NOW_W-1:0] now_ms;
		logic [RAW_W-1:0] adc_raw;
	} bgs_in_t;

	typedef struct packed {
		logic             switch_on;
		logic             result_valid;
		logic [MV_W-1:0]  avg_voltage_mv;
		logic [LVL_W-1:0] level_pct;
	} bgs_out_t;

	typedef struct packed {
		logic [15:0] stabilize_ms;
		logic [15:0] measure_ms;
		logic [15:0] poll_seconds;
		logic [4:0]  adc_bits;
		logic [15:0] vref_mv;
		logic [11:0] divider_q8;
		logic [19:0] min_batt_mv;
		logic [19:0] max_batt_mv;
	} bgs_cfg_t;

	localparam bgs_cfg_t CFG_RESET = '{
		stabilize_ms: 16'd50,
		measure_ms:   16'd100,
		poll_seconds: 16'd60,
		adc_bits:     5'd10,
		vref_mv:      16'd3300,
		divider_q8:   12'd256,
		min_batt_mv:  20'd2000,
		max_batt_mv:  20'd3000
	};

	typedef struct packed {
		logic               start;
		logic [MUL_A_W-1:0] a;
		logic [MUL_B_W-1:0] b;
	} bgs_mul_req_t;

	typedef struct packed {
		logic                 start;
		logic [DIV_NUM_W-1:0] num;
		logic [DIV_DEN_W-1:0] den;
	} bgs_div_req_t;

	typedef enum logic [1:0] {
		PH_IDLE = 2'd0,
		PH_STAB = 2'd1,
		PH_MEAS = 2'd2
	} bgs_phase_t;

	typedef enum logic [3:0] {
		ST_WAIT,
		ST_MUL_V,
		ST_MUL_D,
		ST_DIV_MV,
		ST_FIN_CHK,
		ST_DIV_AVG,
		ST_LVL_CHK,
		ST_MUL_L,
		ST_DIV_L,
		ST_DONE
	} bgs_state_t;

endpackage

@@ hdl/bgs_cfg_regs.sv @@
// ---------------------------------------------------------------------------
// bgs_cfg_regs
// configuration register file with reset defaults, write only
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module bgs_cfg_regs (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [bgs_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [bgs_pkg::CFG_DATA_W-1:0] cfg_data,
	output bgs_pkg::bgs_cfg_t              cfg
);
	import bgs_pkg::*;

	bgs_cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= CFG_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_STABILIZE_MS: cfg_q.stabilize_ms <= cfg_data[15:0];
				CFG_MEASURE_MS:   cfg_q.measure_ms   <= cfg_data[15:0];
				CFG_POLL_SECONDS: cfg_q.poll_seconds <= cfg_data[15:0];
				CFG_ADC_BITS:     cfg_q.adc_bits     <= cfg_data[4:0];
				CFG_VREF_MV:      cfg_q.vref_mv      <= cfg_data[15:0];
				CFG_DIVIDER_Q8:   cfg_q.divider_q8   <= cfg_data[11:0];
				CFG_MIN_BATT_MV:  cfg_q.min_batt_mv  <= cfg_data[19:0];
				CFG_MAX_BATT_MV:  cfg_q.max_batt_mv  <= cfg_data[19:0];
				default:          cfg_q <= cfg_q;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

@@ hdl/bgs_serial_mul.sv @@
// ---------------------------------------------------------------------------
// bgs_serial_mul
// shift-add multiplier, one multiplier bit per cycle, lsb first
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module bgs_serial_mul (
	input  logic                        clk,
	input  logic                        arst_n,
	input  bgs_pkg::bgs_mul_req_t       req,
	output logic                        busy,
	output logic [bgs_pkg::MUL_P_W-1:0] prod
);
	import bgs_pkg::*;

	logic                 busy_q;
	logic [MUL_CNT_W-1:0] cnt_q;
	logic [MUL_P_W-1:0]   a_q;
	logic [MUL_P_W-1:0]   acc_q;
	logic [MUL_B_W-1:0]   b_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (req.start) begin
			busy_q <= 1'b1;
			cnt_q  <= MUL_CNT_W'(MUL_B_W);
		end else if (busy_q) begin
			cnt_q <= cnt_q - MUL_CNT_W'(1);
			if (cnt_q == MUL_CNT_W'(1)) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			a_q   <= MUL_P_W'(req.a);
			b_q   <= req.b;
			acc_q <= '0;
		end else if (busy_q) begin
			if (b_q[0]) begin
				acc_q <= acc_q + a_q;
			end
			a_q <= a_q << 1;
			b_q <= b_q >> 1;
		end
	end

	assign busy = busy_q;
	assign prod = acc_q;

endmodule

@@ hdl/bgs_serial_div.sv @@
// ---------------------------------------------------------------------------
// bgs_serial_div
// restoring divider, one quotient bit per cycle, msb first
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module bgs_serial_div (
	input  logic                          clk,
	input  logic                          arst_n,
	input  bgs_pkg::bgs_div_req_t         req,
	output logic                          busy,
	output logic [bgs_pkg::DIV_NUM_W-1:0] quot
);
	import bgs_pkg::*;

	logic                 busy_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic [DIV_NUM_W-1:0] num_q;
	logic [DIV_DEN_W-1:0] den_q;
	logic [DIV_DEN_W-1:0] rem_q;
	logic [DIV_DEN_W:0]   trial;
	logic [DIV_DEN_W+1:0] diff;

	assign trial = {rem_q, num_q[DIV_NUM_W-1]};
	assign diff  = {1'b0, trial} - {2'b00, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (req.start) begin
			busy_q <= 1'b1;
			cnt_q  <= DIV_CNT_W'(DIV_NUM_W);
		end else if (busy_q) begin
			cnt_q <= cnt_q - DIV_CNT_W'(1);
			if (cnt_q == DIV_CNT_W'(1)) begin
				busy_q <= 1'b0;
			end
		end
	end

	// numerator shifts out at the top while quotient bits enter at the bottom
	always_ff @(posedge clk) begin
		if (req.start) begin
			num_q <= req.num;
			den_q <= req.den;
			rem_q <= '0;
		end else if (busy_q) begin
			if (!diff[DIV_DEN_W+1]) begin
				rem_q <= diff[DIV_DEN_W-1:0];
				num_q <= {num_q[DIV_NUM_W-2:0], 1'b1};
			end else begin
				rem_q <= trial[DIV_DEN_W-1:0];
				num_q <= {num_q[DIV_NUM_W-2:0], 1'b0};
			end
		end
	end

	assign busy = busy_q;
	assign quot = num_q;

endmodule

@@ hdl/battery_gauge_sequencer.sv @@
// ---------------------------------------------------------------------------
// battery_gauge_sequencer
// poll in idle or stabilizing phase: goes straight to the done state, next item once the result is loaded
// measuring poll with a sample: runs the 16-step serial
// multiplier twice and the 36-step serial divider once
// finishing poll: adds the average division and, unless the level clamps, the level multiply and division
// reset: default configuration, idle phase, deadline zero, switch off, no result
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "battery_gauge_sequencer_assert.svh"

module battery_gauge_sequencer (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  bgs_pkg::bgs_in_t               in_data,
	output logic                           out_valid,
	input  logic                           out_stall,
	output bgs_pkg::bgs_out_t              out_data,
	input  logic                           cfg_we,
	input  logic [bgs_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [bgs_pkg::CFG_DATA_W-1:0] cfg_data
);
	import bgs_pkg::*;

	bgs_cfg_t     cfg;
	bgs_mul_req_t mul_req;
	bgs_div_req_t div_req;
	logic         mul_busy;
	logic         div_busy;
	logic [MUL_P_W-1:0]   mul_prod;
	logic [DIV_NUM_W-1:0] div_quot;

	bgs_state_t state_q, state_d;
	bgs_phase_t phase_q;
	logic [NOW_W-1:0] deadline_q;
	logic [SUM_W-1:0] sum_q;
	logic [CNT_W-1:0] count_q;
	logic             switch_q;
	logic             out_valid_q;
	bgs_out_t         out_data_q;

	logic [NOW_W-1:0] now_q;
	logic             fin_q;
	logic             rv_q;
	logic [MV_W-1:0]  avg_q;
	logic [LVL_W-1:0] lvl_q;

	logic             accept;
	logic             out_load;
	logic             ge_now;
	logic             room;
	logic             sw_ctl;
	logic             lvl_zero;
	logic             lvl_full;
	logic [4:0]       fs_bits;
	logic [DIV_DEN_W-1:0] fs_den;
	logic [MV_W-1:0]  quot_sat;
	logic [NOW_W-1:0] poll_ms;

	bgs_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	bgs_serial_mul u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (mul_req),
		.busy   (mul_busy),
		.prod   (mul_prod)
	);

	bgs_serial_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.busy   (div_busy),
		.quot   (div_quot)
	);

	assign accept   = in_valid && !in_stall;
	assign ge_now   = in_data.now_ms >= deadline_q;
	assign room     = count_q < CNT_W'(MAX_SAMPLES);
	assign sw_ctl   = cfg.divider_q8 > DIV_UNITY;
	assign lvl_zero = (cfg.max_batt_mv <= cfg.min_batt_mv) || (avg_q <= cfg.min_batt_mv);
	assign lvl_full = avg_q >= cfg.max_batt_mv;
	assign fs_bits  = (cfg.adc_bits == 5'd0) ? 5'd1 : cfg.adc_bits;
	assign fs_den   = (DIV_DEN_W'(1) << fs_bits) - DIV_DEN_W'(1);
	assign quot_sat = (div_quot[DIV_NUM_W-1:MV_W] != '0) ? MV_MAX : div_quot[MV_W-1:0];
	assign poll_ms  = NOW_W'(cfg.poll_seconds) * NOW_W'(POLL_SCALE);

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_WAIT: begin
				if (in_valid) begin
					if (phase_q == PH_MEAS) begin
						state_d = room ? ST_MUL_V : ST_FIN_CHK;
					end else begin
						state_d = ST_DONE;
					end
				end
			end
			ST_MUL_V:   if (!mul_busy) state_d = ST_MUL_D;
			ST_MUL_D:   if (!mul_busy) state_d = ST_DIV_MV;
			ST_DIV_MV:  if (!div_busy) state_d = ST_FIN_CHK;
			ST_FIN_CHK: state_d = (fin_q && count_q != '0) ? ST_DIV_AVG : ST_DONE;
			ST_DIV_AVG: if (!div_busy) state_d = ST_LVL_CHK;
			ST_LVL_CHK: state_d = (lvl_zero || lvl_full) ? ST_DONE : ST_MUL_L;
			ST_MUL_L:   if (!mul_busy) state_d = ST_DIV_L;
			ST_DIV_L:   if (!div_busy) state_d = ST_DONE;
			ST_DONE:    if (out_load) state_d = ST_WAIT;
			default:    state_d = ST_WAIT;
		endcase
	end

	// unit requests and handshakes
	always_comb begin
		in_stall = 1'b1;
		out_load = 1'b0;
		mul_req  = '0;
		div_req  = '0;
		unique case (state_q)
			ST_WAIT: begin
				in_stall  = 1'b0;
				mul_req.a = MUL_A_W'(in_data.adc_raw);
				mul_req.b = cfg.vref_mv;
				mul_req.start = in_valid && (phase_q == PH_MEAS) && room;
			end
			ST_MUL_V: begin
				mul_req.a = mul_prod[MUL_A_W-1:0];
				mul_req.b = MUL_B_W'(cfg.divider_q8);
				mul_req.start = !mul_busy;
			end
			ST_MUL_D: begin
				div_req.num = mul_prod[MV_SHIFT +: DIV_NUM_W];
				div_req.den = fs_den;
				div_req.start = !mul_busy;
			end
			ST_FIN_CHK: begin
				div_req.num = DIV_NUM_W'(sum_q);
				div_req.den = DIV_DEN_W'(count_q);
				div_req.start = fin_q && (count_q != '0);
			end
			ST_LVL_CHK: begin
				mul_req.a = MUL_A_W'(avg_q - cfg.min_batt_mv);
				mul_req.b = MUL_B_W'(LVL_FULL);
				mul_req.start = !(lvl_zero || lvl_full);
			end
			ST_MUL_L: begin
				div_req.num = mul_prod[DIV_NUM_W-1:0];
				div_req.den = DIV_DEN_W'(cfg.max_batt_mv - cfg.min_batt_mv);
				div_req.start = !mul_busy;
			end
			ST_DONE: begin
				out_load = !out_valid_q || !out_stall;
			end
			default: begin
				in_stall = 1'b1;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_WAIT;
			phase_q     <= PH_IDLE;
			deadline_q  <= '0;
			sum_q       <= '0;
			count_q     <= '0;
			switch_q    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (accept) begin
				unique case (phase_q)
					PH_STAB: begin
						if (ge_now) begin
							phase_q    <= PH_MEAS;
							deadline_q <= in_data.now_ms + NOW_W'(cfg.measure_ms);
						end
					end
					PH_MEAS: begin
						phase_q <= PH_MEAS;
					end
					default: begin
						if (ge_now) begin
							phase_q    <= PH_STAB;
							deadline_q <= in_data.now_ms + NOW_W'(cfg.stabilize_ms);
							if (sw_ctl) begin
								switch_q <= 1'b1;
							end
						end else begin
							phase_q <= PH_IDLE;
						end
					end
				endcase
			end
			if (state_q == ST_DIV_MV && !div_busy) begin
				sum_q   <= sum_q + SUM_W'(quot_sat);
				count_q <= count_q + CNT_W'(1);
			end
			if (state_q == ST_FIN_CHK && fin_q) begin
				phase_q    <= PH_IDLE;
				deadline_q <= now_q + poll_ms;
				sum_q      <= '0;
				count_q    <= '0;
				if (sw_ctl) begin
					switch_q <= 1'b0;
				end
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			now_q <= in_data.now_ms;
			fin_q <= ge_now;
			rv_q  <= 1'b0;
			avg_q <= '0;
			lvl_q <= '0;
		end
		if (state_q == ST_FIN_CHK && fin_q) begin
			rv_q <= 1'b1;
		end
		if (state_q == ST_DIV_AVG && !div_busy) begin
			avg_q <= quot_sat;
		end
		if (state_q == ST_LVL_CHK && !lvl_zero && lvl_full) begin
			lvl_q <= LVL_FULL;
		end
		if (state_q == ST_DIV_L && !div_busy) begin
			lvl_q <= div_quot[LVL_W-1:0];
		end
		if (out_load) begin
			out_data_q.switch_on      <= switch_q;
			out_data_q.result_valid   <= rv_q;
			out_data_q.avg_voltage_mv <= avg_q;
			out_data_q.level_pct      <= lvl_q;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	`BGS_ASSERT_IMP(a_count_cap, clk, arst_n, 1'b1, count_q <= CNT_W'(MAX_SAMPLES), "sample count above capacity")
	`BGS_ASSERT_IMP(a_finish_clears, clk, arst_n, (state_q == ST_DONE) && rv_q, (phase_q == PH_IDLE) && (count_q == '0) && (sum_q == '0), "finished measurement left state behind")
	`BGS_ASSERT_IMP(a_level_range, clk, arst_n, state_q == ST_DONE, lvl_q <= LVL_FULL, "level above full scale")
	`BGS_ASSERT_NXT(a_accept_busy, clk, arst_n, accept, state_q != ST_WAIT, "item accepted without work started")
	`BGS_ASSERT_IMP(a_units_excl, clk, arst_n, mul_busy, !div_busy, "multiplier and divider busy together")

endmodule

@@ tb/sv/battery_gauge_sequencer_tb.sv @@
// ---------------------------------------------------------------------------
// battery_gauge_sequencer_tb
// drives timed polls into the battery gauge sequencer and checks every result
// against an in-bench model of the phase sequencing, sample averaging and
// level scaling; directed corners first, then randomized measurement rounds
// under varied register settings with random stalls on both channels
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module battery_gauge_sequencer_tb;
	import bgs_pkg::*;

	logic                  clk;
	logic                  arst_n;
	logic                  in_valid;
	logic                  in_stall;
	bgs_in_t               in_data;
	logic                  out_valid;
	logic                  out_stall;
	bgs_out_t              out_data;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	battery_gauge_sequencer dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// gauge model state
	bgs_cfg_t    gauge_cfg;
	bgs_phase_t  gauge_phase;
	logic [31:0] gauge_deadline;
	logic [63:0] mv_sum;
	int          mv_count;
	logic        switch_state;

	bgs_out_t    expected_results[$];
	int          mismatch_count;
	logic [31:0] ms_cursor;
	logic        tx_burst;
	logic        rx_quiet;
	int          rx_hold_cycles;

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	initial begin
		#50_000_000;
		$display("Regression FAIL");
		$finish;
	end

	function automatic int idle_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60)
			return $urandom_range(1, 3);
		if (r < 92)
			return $urandom_range(4, 15);
		return $urandom_range(30, 120);
	endfunction

	function automatic logic [MV_W-1:0] raw_to_mv(input logic [RAW_W-1:0] raw);
		int          bits;
		logic [63:0] full_scale;
		logic [63:0] product;
		logic [63:0] quotient;
		bits = (gauge_cfg.adc_bits == 0) ? 1 : int'(gauge_cfg.adc_bits);
		full_scale = ((64'd1 << bits) - 64'd1) * 64'd256;
		product = 64'(raw) * 64'(gauge_cfg.vref_mv) * 64'(gauge_cfg.divider_q8);
		quotient = product / full_scale;
		return (quotient > 64'(MV_MAX)) ? MV_MAX : quotient[MV_W-1:0];
	endfunction

	function automatic logic [LVL_W-1:0] level_of_avg(input logic [MV_W-1:0] avg);
		logic [63:0] pct;
		if (gauge_cfg.max_batt_mv <= gauge_cfg.min_batt_mv || avg <= gauge_cfg.min_batt_mv)
			return '0;
		if (avg >= gauge_cfg.max_batt_mv)
			return LVL_FULL;
		pct = 64'(avg - gauge_cfg.min_batt_mv) * 64'(LVL_FULL)
			/ 64'(gauge_cfg.max_batt_mv - gauge_cfg.min_batt_mv);
		return (pct > 64'(LVL_FULL)) ? LVL_FULL : pct[LVL_W-1:0];
	endfunction

	function automatic bgs_out_t gauge_step(input bgs_in_t poll);
		bgs_out_t    res;
		logic [63:0] avg;
		res = '0;
		case (gauge_phase)
			PH_STAB: begin
				if (poll.now_ms >= gauge_deadline) begin
					gauge_phase = PH_MEAS;
					gauge_deadline = poll.now_ms + 32'(gauge_cfg.measure_ms);
				end
			end
			PH_MEAS: begin
				if (mv_count < MAX_SAMPLES) begin
					mv_sum += 64'(raw_to_mv(poll.adc_raw));
					mv_count++;
				end
				if (poll.now_ms >= gauge_deadline) begin
					gauge_phase = PH_IDLE;
					gauge_deadline = poll.now_ms
						+ 32'(gauge_cfg.poll_seconds) * 32'(POLL_SCALE);
					avg = (mv_count != 0) ? mv_sum / 64'(mv_count) : 64'd0;
					res.avg_voltage_mv = (avg > 64'(MV_MAX)) ? MV_MAX : avg[MV_W-1:0];
					mv_sum = '0;
					mv_count = 0;
					res.level_pct = level_of_avg(res.avg_voltage_mv);
					if (gauge_cfg.divider_q8 > DIV_UNITY)
						switch_state = 1'b0;
					res.result_valid = 1'b1;
				end
			end
			default: begin
				gauge_phase = PH_IDLE;
				if (poll.now_ms >= gauge_deadline) begin
					gauge_phase = PH_STAB;
					gauge_deadline = poll.now_ms + 32'(gauge_cfg.stabilize_ms);
					if (gauge_cfg.divider_q8 > DIV_UNITY)
						switch_state = 1'b1;
				end
			end
		endcase
		res.switch_on = switch_state;
		return res;
	endfunction

	function automatic void note_mismatch(input string what, input logic [31:0] want,
			input logic [31:0] got);
		mismatch_count++;
		if (mismatch_count <= 10)
			$display("mismatch %s: expected %0d, got %0d", what, want, got);
	endfunction

	always @(posedge clk) begin : result_check
		bgs_out_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (expected_results.size() == 0) begin
				note_mismatch("unexpected item", '0, 32'(out_data.avg_voltage_mv));
			end else begin
				want = expected_results.pop_front();
				if (out_data.switch_on !== want.switch_on)
					note_mismatch("switch_on", 32'(want.switch_on), 32'(out_data.switch_on));
				if (out_data.result_valid !== want.result_valid)
					note_mismatch("result_valid", 32'(want.result_valid),
						32'(out_data.result_valid));
				if (out_data.avg_voltage_mv !== want.avg_voltage_mv)
					note_mismatch("avg_voltage_mv", 32'(want.avg_voltage_mv),
						32'(out_data.avg_voltage_mv));
				if (out_data.level_pct !== want.level_pct)
					note_mismatch("level_pct", 32'(want.level_pct), 32'(out_data.level_pct));
			end
		end
	end

	// receiver pacing, long hold-offs counted here
	initial begin : rx_pacing
		int   run_left;
		logic run_stall;
		run_left = 0;
		run_stall = 1'b0;
		out_stall = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (rx_hold_cycles > 0) begin
				run_left = rx_hold_cycles;
				run_stall = 1'b1;
				rx_hold_cycles = 0;
			end else if (run_left <= 0) begin
				run_stall = !rx_quiet && ($urandom_range(0, 99) < 35);
				run_left = run_stall ? idle_len() : $urandom_range(1, 8);
			end
			out_stall <= run_stall;
			run_left--;
		end
	end

	task automatic send_poll(input logic [31:0] now, input logic [RAW_W-1:0] raw);
		int       gap;
		bgs_in_t  poll;
		bgs_out_t want;
		gap = (tx_burst || $urandom_range(0, 1) == 0) ? 0 : idle_len();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		poll.now_ms = now;
		poll.adc_raw = raw;
		in_valid <= 1'b1;
		in_data <= poll;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		want = gauge_step(poll);
		expected_results.insert(expected_results.size(), want);
	endtask

	task automatic drain_results();
		in_valid <= 1'b0;
		while (expected_results.size() > 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] value);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
		case (idx)
			CFG_STABILIZE_MS: gauge_cfg.stabilize_ms = value[15:0];
			CFG_MEASURE_MS:   gauge_cfg.measure_ms = value[15:0];
			CFG_POLL_SECONDS: gauge_cfg.poll_seconds = value[15:0];
			CFG_ADC_BITS:     gauge_cfg.adc_bits = value[4:0];
			CFG_VREF_MV:      gauge_cfg.vref_mv = value[15:0];
			CFG_DIVIDER_Q8:   gauge_cfg.divider_q8 = value[11:0];
			CFG_MIN_BATT_MV:  gauge_cfg.min_batt_mv = value[19:0];
			default:          gauge_cfg.max_batt_mv = value[19:0];
		endcase
	endtask

	task automatic load_config(input bgs_cfg_t c);
		write_reg(CFG_STABILIZE_MS, 20'(c.stabilize_ms));
		write_reg(CFG_MEASURE_MS, 20'(c.measure_ms));
		write_reg(CFG_POLL_SECONDS, 20'(c.poll_seconds));
		write_reg(CFG_ADC_BITS, 20'(c.adc_bits));
		write_reg(CFG_VREF_MV, 20'(c.vref_mv));
		write_reg(CFG_DIVIDER_Q8, 20'(c.divider_q8));
		write_reg(CFG_MIN_BATT_MV, c.min_batt_mv);
		write_reg(CFG_MAX_BATT_MV, c.max_batt_mv);
	endtask

	function automatic bgs_cfg_t random_config();
		bgs_cfg_t    c;
		int unsigned top;
		c.stabilize_ms = ($urandom_range(0, 9) == 0) ? 16'($urandom) : 16'($urandom_range(0, 30));
		c.measure_ms = ($urandom_range(0, 9) == 0) ? 16'($urandom) : 16'($urandom_range(0, 40));
		c.poll_seconds = ($urandom_range(0, 9) == 0) ? 16'($urandom) : 16'($urandom_range(0, 3));
		c.adc_bits = ($urandom_range(0, 19) == 0) ? 5'd0 : 5'($urandom_range(1, 16));
		c.vref_mv = 16'($urandom);
		case ($urandom_range(0, 3))
			0:       c.divider_q8 = DIV_UNITY;
			1:       c.divider_q8 = DIV_UNITY + 12'd1;
			default: c.divider_q8 = 12'($urandom);
		endcase
		top = int'(c.vref_mv) * int'(c.divider_q8) / 256;
		if ($urandom_range(0, 4) == 0) begin
			c.min_batt_mv = 20'($urandom);
			c.max_batt_mv = 20'($urandom);
		end else begin
			c.min_batt_mv = 20'($urandom_range(0, top / 2));
			c.max_batt_mv = c.min_batt_mv + 20'($urandom_range(1, top / 2 + 1));
		end
		return c;
	endfunction

	// polls that follow the phase deadlines, with some stray timestamps unless in fixed-step mode
	task automatic run_round(input int count, input logic fixed_step);
		logic [31:0]      now;
		logic [RAW_W-1:0] raw;
		logic [RAW_W-1:0] full;
		int               r;
		full = (gauge_cfg.adc_bits == 0) ? 16'd1 :
			(gauge_cfg.adc_bits >= 16) ? 16'hFFFF : 16'((32'd1 << gauge_cfg.adc_bits) - 1);
		for (int i = 0; i < count; i++) begin
			r = $urandom_range(0, 99);
			if (fixed_step) begin
				ms_cursor += 32'd1;
			end else if (ms_cursor < gauge_deadline) begin
				if ((gauge_phase == PH_MEAS && r < 85) || (gauge_phase != PH_MEAS && r < 50))
					ms_cursor += 32'($urandom_range(0, 3));
				else
					ms_cursor = gauge_deadline + 32'($urandom_range(0, 2));
			end else begin
				ms_cursor += 32'($urandom_range(0, 3));
			end
			now = (!fixed_step && $urandom_range(0, 99) < 5) ? 32'($urandom) : ms_cursor;
			r = $urandom_range(0, 99);
			if (r < 80)
				raw = 16'($urandom_range(0, full));
			else if (r < 90)
				raw = $urandom_range(0, 1) ? full : 16'd0;
			else
				raw = 16'($urandom);
			send_poll(now, raw);
		end
	endtask

	task automatic test_default_sequence();
		send_poll(32'd0, 16'd0);
		send_poll(32'd49, 16'd512);
		send_poll(32'd50, 16'd1023);
		send_poll(32'd60, 16'd1023);
		send_poll(32'd100, 16'hFFFF);
		send_poll(32'd150, 16'd0);
		drain_results();
	endtask

	task automatic test_saturation_and_switch();
		bgs_cfg_t c;
		c.stabilize_ms = 16'd0;
		c.measure_ms = 16'd0;
		c.poll_seconds = 16'd0;
		c.adc_bits = 5'd1;
		c.vref_mv = 16'hFFFF;
		c.divider_q8 = 12'hFFF;
		c.min_batt_mv = 20'd0;
		c.max_batt_mv = MV_MAX;
		load_config(c);
		send_poll(32'd60150, 16'hFFFF);
		send_poll(32'd60150, 16'hFFFF);
		send_poll(32'd60150, 16'hFFFF);
		drain_results();
	endtask

	// equal limits, zero resolution, divider dropped while the switch is on
	task automatic test_level_corners();
		write_reg(CFG_MIN_BATT_MV, 20'd500);
		write_reg(CFG_MAX_BATT_MV, 20'd500);
		write_reg(CFG_ADC_BITS, 20'd0);
		write_reg(CFG_VREF_MV, 20'd1000);
		write_reg(CFG_DIVIDER_Q8, 20'd300);
		send_poll(32'd60151, 16'd1);
		send_poll(32'd60151, 16'd0);
		drain_results();
		write_reg(CFG_DIVIDER_Q8, 20'(DIV_UNITY));
		send_poll(32'd60152, 16'd1);
		send_poll(32'd60152, 16'd1);
		send_poll(32'd60152, 16'd1);
		send_poll(32'd60152, 16'd1);
		drain_results();
	endtask

	task automatic test_time_wrap();
		write_reg(CFG_STABILIZE_MS, 20'd100);
		write_reg(CFG_MEASURE_MS, 20'd100);
		write_reg(CFG_POLL_SECONDS, 20'd1);
		write_reg(CFG_ADC_BITS, 20'd16);
		write_reg(CFG_DIVIDER_Q8, 20'd1000);
		send_poll(32'hFFFF_FFC0, 16'h8000);
		send_poll(32'hFFFF_FFD0, 16'h7FFF);
		send_poll(32'hFFFF_FFFF, 16'hFFFF);
		send_poll(32'd5, 16'h0001);
		send_poll(32'd0, 16'h0000);
		drain_results();
	endtask

	// measuring window longer than the sample store
	task automatic test_full_buffer();
		bgs_cfg_t c;
		c = random_config();
		c.stabilize_ms = 16'd0;
		c.measure_ms = 16'd100;
		c.poll_seconds = 16'd0;
		c.adc_bits = 5'd12;
		load_config(c);
		ms_cursor = gauge_deadline;
		run_round(110, 1'b1);
		drain_results();
	endtask

	// receiver holds off while the sender keeps offering items
	task automatic test_receiver_holdoff();
		write_reg(CFG_STABILIZE_MS, 20'd0);
		write_reg(CFG_MEASURE_MS, 20'd3);
		write_reg(CFG_POLL_SECONDS, 20'd0);
		ms_cursor = gauge_deadline;
		tx_burst = 1'b1;
		rx_hold_cycles = 600;
		run_round(16, 1'b1);
		tx_burst = 1'b0;
		drain_results();
	endtask

	task automatic test_random_rounds();
		for (int k = 0; k < 14; k++) begin
			load_config(random_config());
			tx_burst = ($urandom_range(0, 3) == 0);
			rx_quiet = ($urandom_range(0, 3) == 0);
			run_round($urandom_range(60, 100), 1'b0);
			drain_results();
		end
		tx_burst = 1'b0;
		rx_quiet = 1'b0;
	endtask

	initial begin : main_sequence
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_data = '0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		tx_burst = 1'b0;
		rx_quiet = 1'b0;
		rx_hold_cycles = 0;
		mismatch_count = 0;
		ms_cursor = '0;
		gauge_cfg = CFG_RESET;
		gauge_phase = PH_IDLE;
		gauge_deadline = '0;
		mv_sum = '0;
		mv_count = 0;
		switch_state = 1'b0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_default_sequence();
		test_saturation_and_switch();
		test_level_corners();
		test_time_wrap();
		test_full_buffer();
		test_receiver_holdoff();
		test_random_rounds();
		drain_results();
		repeat (200) @(posedge clk);
		if (mismatch_count == 0 && expected_results.size() == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule

@@ battery_gauge_sequencer.f @@
+incdir+hdl
hdl/bgs_pkg.sv
hdl/bgs_cfg_regs.sv
hdl/bgs_serial_mul.sv
hdl/bgs_serial_div.sv
hdl/battery_gauge_sequencer.sv
tb/sv/battery_gauge_sequencer_tb.sv
